>>> hdl/ipv6_tap_pkg.sv
// Shared types, character codes and digit decode for the IPv6 text address parser.
`timescale 1ns / 1ps
package ipv6_tap_pkg;

	localparam int NUM_GROUPS  = 8;
	localparam int GROUP_W     = 16;
	localparam int COUNT_W     = 4;
	localparam int GAP_W       = 3;
	localparam int LAST_GROUP  = 7;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	typedef logic [GROUP_W-1:0] group_t;

	// Kind of the previous character, used to spot a double colon
	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_HEX   = 2'd1,
		KIND_COLON = 2'd2
	} char_kind_t;

	// Flag a hex digit character
	function automatic logic is_hex(input logic [7:0] c);
		is_hex = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
			((c >= CH_LA) && (c <= CH_LF));
	endfunction

	// Value of a hex digit character; zero for anything else
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if ((c >= CH_0) && (c <= CH_9)) begin
			v = c - CH_0;
		end else if ((c >= CH_UA) && (c <= CH_UF)) begin
			v = c - CH_UA + 8'd10;
		end else if ((c >= CH_LA) && (c <= CH_LF)) begin
			v = c - CH_LA + 8'd10;
		end
		hex_value = v[3:0];
	endfunction

endpackage

>>> hdl/ipv6_text_address_parser_unit.sv
// IPv6 text address parser: character stream in, 128-bit address with error flag out.
//
// Usage: feed the address text one character per beat on text_char, with is_last
// high on the final character. Hex digits build a 16-bit group, a colon stores
// it, and a double colon marks the zero-compression gap. A second gap sets
// parse_error and the previously committed address is reported unchanged.
// Exactly one result beat follows each beat that carries is_last; other beats
// produce no result.
// Timing: the input register takes the last character at acceptance, the result
// register takes its result when that beat fires. Throughput: one character per
// cycle while no final character waits (see Stall); all per-character work and the
// final group shuffle sit between those two registers.
// Reset: clears the committed address to all zero, drops any text in progress
// and empties both registers.
// Stall: while a result waits with out_ready low, non-final characters keep
// flowing; a final character waits in the input register until the result
// register frees, and in_ready drops behind it.
`timescale 1ns / 1ps
module ipv6_text_address_parser_unit
	import ipv6_tap_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_char,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] addr_upper,
	output logic [63:0] addr_lower,
	output logic        parse_error
);

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Parser state
	group_t             stored_q [NUM_GROUPS];
	group_t             work_q   [NUM_GROUPS];
	group_t             accum_q;
	logic [COUNT_W-1:0] count_q;
	char_kind_t         kind_q;
	logic [GAP_W-1:0]   gap_q;
	logic               err_q;

	// Result register
	logic        out_valid_q;
	logic [63:0] upper_q;
	logic [63:0] lower_q;
	logic        error_q;

	// Next state
	group_t             work_n   [NUM_GROUPS];
	group_t             fill_t   [NUM_GROUPS];
	group_t             fin_t    [NUM_GROUPS];
	group_t             commit_n [NUM_GROUPS];
	group_t             accum_n;
	logic [COUNT_W-1:0] count_n;
	char_kind_t         kind_n;
	logic [GAP_W-1:0]   gap_n;
	logic               err_n;
	logic               take;
	logic               fire;

	// Process the held beat unless it is final and the result slot is busy
	assign fire     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Apply one character to the per-text state
	always_comb begin
		for (int i = 0; i < NUM_GROUPS; i++) begin
			work_n[i] = work_q[i];
		end
		accum_n = accum_q;
		count_n = count_q;
		kind_n  = kind_q;
		gap_n   = gap_q;
		err_n   = err_q;
		take    = !err_q && !count_q[COUNT_W-1];
		if (take) begin
			if (is_hex(char_s1)) begin
				accum_n = {accum_q[GROUP_W-5:0], hex_value(char_s1)};
				kind_n  = KIND_HEX;
			end else if (char_s1 == CH_COLON) begin
				work_n[count_q[GAP_W-1:0]] = accum_q;
				accum_n = '0;
				count_n = count_q + 1'b1;
				if (kind_q == KIND_COLON) begin
					if (gap_q == '0) begin
						gap_n = count_q[GAP_W-1:0];
					end else begin
						err_n = 1'b1;
					end
				end
				kind_n = KIND_COLON;
			end else begin
				kind_n = KIND_OTHER;
			end
		end
	end

	// Place the trailing group, shift the groups behind the gap, zero the gap; keep the stored address on an error
	always_comb begin
		logic [4:0] sum;
		logic [4:0] src;
		for (int i = 0; i < NUM_GROUPS; i++) begin
			fill_t[i] = work_n[i];
		end
		if (!count_n[COUNT_W-1]) begin
			fill_t[count_n[GAP_W-1:0]] = accum_n;
		end
		for (int i = 0; i < NUM_GROUPS; i++) begin
			sum = 5'(i) + 5'(count_n);
			src = sum - 5'(LAST_GROUP);
			if (gap_n == '0) begin
				fin_t[i] = fill_t[i];
			end else if (count_n[COUNT_W-1]) begin
				fin_t[i] = ((5'(i) + 5'd1) >= 5'(gap_n)) ? '0 : fill_t[i];
			end else if (sum >= (5'(gap_n) + 5'(LAST_GROUP))) begin
				fin_t[i] = fill_t[src[GAP_W-1:0]];
			end else if (5'(i) >= 5'(gap_n)) begin
				fin_t[i] = '0;
			end else begin
				fin_t[i] = fill_t[i];
			end
			commit_n[i] = err_n ? stored_q[i] : fin_t[i];
		end
	end

	// Hold the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= text_char;
			last_s1 <= is_last;
		end
	end

	// Advance the parser state; commit and restart on the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GROUPS; i++) begin
				stored_q[i] <= '0;
				work_q[i]   <= '0;
			end
			accum_q <= '0;
			count_q <= '0;
			kind_q  <= KIND_OTHER;
			gap_q   <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				for (int i = 0; i < NUM_GROUPS; i++) begin
					stored_q[i] <= commit_n[i];
					work_q[i]   <= commit_n[i];
				end
				accum_q <= '0;
				count_q <= '0;
				kind_q  <= KIND_OTHER;
				gap_q   <= '0;
				err_q   <= 1'b0;
			end else begin
				for (int i = 0; i < NUM_GROUPS; i++) begin
					work_q[i] <= work_n[i];
				end
				accum_q <= accum_n;
				count_q <= count_n;
				kind_q  <= kind_n;
				gap_q   <= gap_n;
				err_q   <= err_n;
			end
		end
	end

	// Result beat valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			upper_q <= {commit_n[0], commit_n[1], commit_n[2], commit_n[3]};
			lower_q <= {commit_n[4], commit_n[5], commit_n[6], commit_n[7]};
			error_q <= err_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign addr_upper  = upper_q;
	assign addr_lower  = lower_q;
	assign parse_error = error_q;

endmodule
